// ----- hw/rtl/lte_pkg.sv -----
`default_nettype none
package lte_pkg;

  localparam int TARGET_INPUTS = 5;
  localparam int TS_W          = 64;
  localparam int WORD_W        = 32;
  localparam int PIX_W         = 12;
  localparam int CPP_W         = 16;
  localparam int CM_W          = 28;
  localparam int HALF_W        = 14;
  localparam int SQ_W          = 58;
  localparam int DIST_W        = 29;
  localparam int CNT_W         = 32;
  localparam int LEDC_W        = 3;
  localparam int PRIN_W        = 2;
  localparam int REG_IDX_W     = 3;
  localparam int PADDR_W       = 5;
  localparam int APB_W         = 32;

  localparam logic [REG_IDX_W-1:0] REG_LED_COUNT     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRINCIPAL_LED = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CM_PER_PIXEL  = 3'd4;

  localparam logic [PRIN_W-1:0] PL_TARGET0 = 2'd0;
  localparam logic [PRIN_W-1:0] PL_RED     = 2'd1;
  localparam logic [PRIN_W-1:0] PL_GREEN   = 2'd2;
  localparam logic [PRIN_W-1:0] PL_BLUE    = 2'd3;

  localparam logic [LEDC_W-1:0] LED_COUNT_RST     = 3'd1;
  localparam logic [PRIN_W-1:0] PRINCIPAL_LED_RST = PL_TARGET0;
  localparam logic [PIX_W-1:0]  FRAME_WIDTH_RST   = 12'd641;
  localparam logic [PIX_W-1:0]  FRAME_HEIGHT_RST  = 12'd481;
  localparam logic [CPP_W-1:0]  CM_PER_PIXEL_RST  = 16'd256;

  typedef struct packed {
    logic            ok;
    logic [CM_W-1:0] x;
    logic [CM_W-1:0] y;
  } lte_spot_t;

  typedef struct packed {
    lte_spot_t spot;
    logic      red;
    logic      green;
    logic      blue;
  } lte_lane_t;

  typedef struct packed {
    logic      bad;
    lte_spot_t pos;
    lte_spot_t red;
    lte_spot_t blue;
  } lte_merge_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lte_in_if.sv -----
`default_nettype none
interface lte_in_if;
  logic                       valid;
  logic                       ready;
  logic [lte_pkg::TS_W-1:0]   timestamp_us;
  logic [lte_pkg::WORD_W-1:0] target_word0;
  logic [lte_pkg::WORD_W-1:0] target_word1;
  logic [lte_pkg::WORD_W-1:0] target_word2;
  logic [lte_pkg::WORD_W-1:0] target_word3;
  logic [lte_pkg::WORD_W-1:0] target_word4;

  modport source (
    output valid, timestamp_us, target_word0, target_word1, target_word2,
           target_word3, target_word4,
    input  ready
  );

  modport sink (
    input  valid, timestamp_us, target_word0, target_word1, target_word2,
           target_word3, target_word4,
    output ready
  );
endinterface
`default_nettype wire

// ----- hw/rtl/lte_out_if.sv -----
`default_nettype none
interface lte_out_if;
  logic                       valid;
  logic                       ready;
  logic [lte_pkg::TS_W-1:0]   timestamp_out;
  logic                       pos_valid;
  logic [lte_pkg::CM_W-1:0]   pos_x;
  logic [lte_pkg::CM_W-1:0]   pos_y;
  logic                       dist_valid;
  logic [lte_pkg::DIST_W-1:0] led_distance;
  logic                       out_of_range;
  logic [lte_pkg::CNT_W-1:0]  record_count;
  logic [lte_pkg::CNT_W-1:0]  valid_count;
  logic [lte_pkg::CNT_W-1:0]  bad_count;

  modport source (
    output valid, timestamp_out, pos_valid, pos_x, pos_y, dist_valid, led_distance,
           out_of_range, record_count, valid_count, bad_count,
    input  ready
  );

  modport sink (
    input  valid, timestamp_out, pos_valid, pos_x, pos_y, dist_valid, led_distance,
           out_of_range, record_count, valid_count, bad_count,
    output ready
  );
endinterface
`default_nettype wire

// ----- hw/rtl/lte_lane.sv -----
`default_nettype none
module lte_lane (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [lte_pkg::WORD_W-1:0]  word,
  input  wire logic [lte_pkg::PIX_W-1:0]   frame_width,
  input  wire logic [lte_pkg::PIX_W-1:0]   frame_height,
  input  wire logic [lte_pkg::CPP_W-1:0]   cm_per_pixel,
  output lte_pkg::lte_lane_t               lane_o
);

  logic [lte_pkg::PIX_W-1:0] px;
  logic [lte_pkg::PIX_W-1:0] py;
  logic [lte_pkg::PIX_W-1:0] py_inv;
  logic [2:0]                rgb;
  logic                      in_frame;
  logic                      single;
  logic [lte_pkg::CM_W-1:0]  x_cm;
  logic [lte_pkg::CM_W-1:0]  y_cm;
  lte_pkg::lte_lane_t        lane_r;

  assign px       = word[11:0];
  assign py       = word[27:16];
  assign rgb      = word[30:28];
  assign in_frame = (px != '0) && (px <= frame_width) && (py != '0) && (py <= frame_height);
  assign single   = (rgb == 3'b001) || (rgb == 3'b010) || (rgb == 3'b100);
  assign py_inv   = frame_height - py;
  assign x_cm     = {{lte_pkg::CPP_W{1'b0}}, px} * {{lte_pkg::PIX_W{1'b0}}, cm_per_pixel};
  assign y_cm     = {{lte_pkg::CPP_W{1'b0}}, py_inv} * {{lte_pkg::PIX_W{1'b0}}, cm_per_pixel};

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r.spot.ok <= in_frame;
      lane_r.spot.x  <= in_frame ? x_cm : '0;
      lane_r.spot.y  <= in_frame ? y_cm : '0;
      lane_r.red     <= single & rgb[2];
      lane_r.green   <= single & rgb[1];
      lane_r.blue    <= single & rgb[0];
    end
  end

  assign lane_o = lane_r;

endmodule
`default_nettype wire

// ----- hw/rtl/lte_merge.sv -----
`default_nettype none
module lte_merge #(
  parameter int NLANES = 5
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  lte_pkg::lte_lane_t                lanes [NLANES],
  input  wire logic [lte_pkg::LEDC_W-1:0]   led_count,
  input  wire logic [lte_pkg::PRIN_W-1:0]   principal_led,
  output lte_pkg::lte_merge_t               merge_o
);

  localparam logic [lte_pkg::LEDC_W-1:0] NMAX = lte_pkg::LEDC_W'(NLANES);

  logic [lte_pkg::LEDC_W-1:0] n;
  lte_pkg::lte_spot_t         red;
  lte_pkg::lte_spot_t         green;
  lte_pkg::lte_spot_t         blue;
  lte_pkg::lte_spot_t         pos;
  logic                       bad;
  lte_pkg::lte_merge_t        merge_r;

  always_comb begin
    n = led_count;
    if (n == '0) n = lte_pkg::LEDC_W'(1);
    if (n > NMAX) n = NMAX;
    bad   = 1'b0;
    red   = '0;
    green = '0;
    blue  = '0;
    // downward scan: the lowest examined index wins
    for (int i = NLANES - 1; i >= 0; i--) begin
      if (lte_pkg::LEDC_W'(i) < n) begin
        if (!lanes[i].spot.ok) bad = 1'b1;
        if (lanes[i].red) red = lanes[i].spot;
        if (lanes[i].green) green = lanes[i].spot;
        if (lanes[i].blue) blue = lanes[i].spot;
      end
    end
    case (principal_led)
      lte_pkg::PL_RED:   pos = red;
      lte_pkg::PL_GREEN: pos = green;
      lte_pkg::PL_BLUE:  pos = blue;
      default:           pos = lanes[0].spot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      merge_r.bad  <= bad;
      merge_r.pos  <= pos;
      merge_r.red  <= red;
      merge_r.blue <= blue;
    end
  end

  assign merge_o = merge_r;

endmodule
`default_nettype wire

// ----- hw/rtl/lte_dist.sv -----
`default_nettype none
module lte_dist (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  lte_pkg::lte_spot_t               red,
  input  lte_pkg::lte_spot_t               blue,
  output logic                             done_o,
  output logic [lte_pkg::DIST_W-1:0]       root_o
);

  localparam int PROD_W = lte_pkg::CM_W + lte_pkg::HALF_W;

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_SQRT, D_DONE} dstate_t;

  dstate_t                   state_r;
  logic [lte_pkg::CM_W-1:0]  dx_r;
  logic [lte_pkg::CM_W-1:0]  dy_r;
  logic [2:0]                step_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      sh_r;
  logic [lte_pkg::SQ_W-1:0]  acc_r;
  logic [lte_pkg::SQ_W-1:0]  v_r;
  logic [lte_pkg::SQ_W-1:0]  root_r;
  logic [lte_pkg::SQ_W-1:0]  bit_r;

  logic [lte_pkg::CM_W-1:0]   dx_nxt;
  logic [lte_pkg::CM_W-1:0]   dy_nxt;
  logic [lte_pkg::CM_W-1:0]   mcand;
  logic [lte_pkg::HALF_W-1:0] mplier;
  logic [PROD_W-1:0]          prod_nxt;
  logic [lte_pkg::SQ_W-1:0]   addend;
  logic [lte_pkg::SQ_W-1:0]   acc_nxt;
  logic [lte_pkg::SQ_W-1:0]   trial;
  logic                       fits;

  assign dx_nxt   = (red.x > blue.x) ? red.x - blue.x : blue.x - red.x;
  assign dy_nxt   = (red.y > blue.y) ? red.y - blue.y : blue.y - red.y;
  assign mcand    = step_r[1] ? dy_r : dx_r;
  assign mplier   = step_r[0] ? mcand[lte_pkg::CM_W-1:lte_pkg::HALF_W]
                              : mcand[lte_pkg::HALF_W-1:0];
  assign prod_nxt = {{lte_pkg::HALF_W{1'b0}}, mcand} * {{lte_pkg::CM_W{1'b0}}, mplier};
  assign addend   = sh_r ? lte_pkg::SQ_W'({prod_r, {lte_pkg::HALF_W{1'b0}}})
                         : lte_pkg::SQ_W'(prod_r);
  assign acc_nxt  = acc_r + addend;
  assign trial    = root_r + bit_r;
  assign fits     = v_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      case (state_r)
        D_IDLE: begin
          if (start) begin
            dx_r    <= dx_nxt;
            dy_r    <= dy_nxt;
            step_r  <= '0;
            acc_r   <= '0;
            state_r <= D_MUL;
          end
        end
        D_MUL: begin
          // four 28x14 partial products; each registered product is added to acc_r in the step after
          if (step_r != 3'd4) begin
            prod_r <= prod_nxt;
            sh_r   <= step_r[0];
          end
          if (step_r != 3'd0) acc_r <= acc_nxt;
          step_r <= step_r + 3'd1;
          if (step_r == 3'd4) begin
            v_r     <= acc_nxt;
            root_r  <= '0;
            bit_r   <= lte_pkg::SQ_W'(1) << (lte_pkg::SQ_W - 2);
            state_r <= D_SQRT;
          end
        end
        D_SQRT: begin
          if (fits) begin
            v_r    <= v_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) state_r <= D_DONE;
        end
        D_DONE: begin
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign done_o = (state_r == D_DONE);
  assign root_o = root_r[lte_pkg::DIST_W-1:0];

endmodule
`default_nettype wire

// ----- hw/rtl/led_tracker_target_extract.sv -----
// Tracker record target extractor.
// in_ch (valid/ready) carries one record: a timestamp and five packed target
// words. out_ch (valid/ready) carries one result per record: principal
// position, red-to-blue distance, out-of-range flag and saturating counters.
// Registers are written over the APB port (byte address 4*index); the user
// must write them only while idle, the block itself does not enforce this.
// One record is worked on at a time: the target lanes register the words, the
// merge registers the colour spots, a start state launches the distance unit
// (partial products, then a bit-serial square root, then a done state), and
// the result is loaded into the output register before a new record is taken.
// The result sits in an output register: the next record is taken while it
// waits. If the receiver stalls, the finished result of the following record
// is held inside until the output register frees, and no further record is
// taken meanwhile.
// Synchronous active-low reset clears the counters, the control state and
// loads the register defaults (one target, target 0 principal, 641x481 frame,
// 1.0 cm per pixel).
`default_nettype none
module led_tracker_target_extract #(
  parameter int MAX_TARGETS = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lte_in_if.sink                             in_ch,
  lte_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lte_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [lte_pkg::APB_W-1:0]     pwdata,
  output logic      [lte_pkg::APB_W-1:0]     prdata,
  output logic                               pready
);

  localparam int LANES = (MAX_TARGETS < lte_pkg::TARGET_INPUTS) ? MAX_TARGETS
                                                                : lte_pkg::TARGET_INPUTS;

  typedef enum logic [2:0] {S_IDLE, S_MERGE, S_START, S_RUN, S_OUT} state_t;

  state_t                         state_r;
  logic [lte_pkg::LEDC_W-1:0]     led_count_r;
  logic [lte_pkg::PRIN_W-1:0]     principal_led_r;
  logic [lte_pkg::PIX_W-1:0]      frame_width_r;
  logic [lte_pkg::PIX_W-1:0]      frame_height_r;
  logic [lte_pkg::CPP_W-1:0]      cm_per_pixel_r;
  logic [lte_pkg::CNT_W-1:0]      records_r;
  logic [lte_pkg::CNT_W-1:0]      valid_seen_r;
  logic [lte_pkg::CNT_W-1:0]      bad_seen_r;
  logic [lte_pkg::CNT_W-1:0]      records_nxt;
  logic [lte_pkg::CNT_W-1:0]      valid_seen_nxt;
  logic [lte_pkg::CNT_W-1:0]      bad_seen_nxt;
  logic [lte_pkg::TS_W-1:0]       ts_r;

  logic                           out_valid_r;
  logic [lte_pkg::TS_W-1:0]       out_ts_r;
  logic                           out_pos_valid_r;
  logic [lte_pkg::CM_W-1:0]       out_pos_x_r;
  logic [lte_pkg::CM_W-1:0]       out_pos_y_r;
  logic                           out_dist_valid_r;
  logic [lte_pkg::DIST_W-1:0]     out_dist_r;
  logic                           out_bad_r;

  logic [lte_pkg::WORD_W-1:0]     words [lte_pkg::TARGET_INPUTS];
  lte_pkg::lte_lane_t             lanes [LANES];
  lte_pkg::lte_merge_t            merged;
  logic                           accept;
  logic                           cfg_wr;
  logic [lte_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                           dist_done;
  logic [lte_pkg::DIST_W-1:0]     dist_root;
  logic                           dist_ok;
  logic                           out_free;

  assign words[0] = in_ch.target_word0;
  assign words[1] = in_ch.target_word1;
  assign words[2] = in_ch.target_word2;
  assign words[3] = in_ch.target_word3;
  assign words[4] = in_ch.target_word4;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lte_lane u_lane (
      .clk          (clk),
      .en           (accept),
      .word         (words[g]),
      .frame_width  (frame_width_r),
      .frame_height (frame_height_r),
      .cm_per_pixel (cm_per_pixel_r),
      .lane_o       (lanes[g])
    );
  end

  lte_merge #(.NLANES(LANES)) u_merge (
    .clk           (clk),
    .en            (state_r == S_MERGE),
    .lanes         (lanes),
    .led_count     (led_count_r),
    .principal_led (principal_led_r),
    .merge_o       (merged)
  );

  lte_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_START),
    .red    (merged.red),
    .blue   (merged.blue),
    .done_o (dist_done),
    .root_o (dist_root)
  );

  assign dist_ok  = merged.red.ok && merged.blue.ok;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    records_nxt    = (&records_r) ? records_r : records_r + 1'b1;
    valid_seen_nxt = valid_seen_r;
    bad_seen_nxt   = bad_seen_r;
    if (merged.pos.ok && !(&valid_seen_r)) valid_seen_nxt = valid_seen_r + 1'b1;
    if (merged.bad && !(&bad_seen_r)) bad_seen_nxt = bad_seen_r + 1'b1;
  end

  assign pready  = 1'b1;
  assign reg_idx = paddr[lte_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      lte_pkg::REG_LED_COUNT:     prdata = lte_pkg::APB_W'(led_count_r);
      lte_pkg::REG_PRINCIPAL_LED: prdata = lte_pkg::APB_W'(principal_led_r);
      lte_pkg::REG_FRAME_WIDTH:   prdata = lte_pkg::APB_W'(frame_width_r);
      lte_pkg::REG_FRAME_HEIGHT:  prdata = lte_pkg::APB_W'(frame_height_r);
      lte_pkg::REG_CM_PER_PIXEL:  prdata = lte_pkg::APB_W'(cm_per_pixel_r);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r     <= lte_pkg::LED_COUNT_RST;
      principal_led_r <= lte_pkg::PRINCIPAL_LED_RST;
      frame_width_r   <= lte_pkg::FRAME_WIDTH_RST;
      frame_height_r  <= lte_pkg::FRAME_HEIGHT_RST;
      cm_per_pixel_r  <= lte_pkg::CM_PER_PIXEL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        lte_pkg::REG_LED_COUNT:     led_count_r     <= pwdata[lte_pkg::LEDC_W-1:0];
        lte_pkg::REG_PRINCIPAL_LED: principal_led_r <= pwdata[lte_pkg::PRIN_W-1:0];
        lte_pkg::REG_FRAME_WIDTH:   frame_width_r   <= pwdata[lte_pkg::PIX_W-1:0];
        lte_pkg::REG_FRAME_HEIGHT:  frame_height_r  <= pwdata[lte_pkg::PIX_W-1:0];
        lte_pkg::REG_CM_PER_PIXEL:  cm_per_pixel_r  <= pwdata[lte_pkg::CPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      records_r    <= '0;
      valid_seen_r <= '0;
      bad_seen_r   <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            ts_r    <= in_ch.timestamp_us;
            state_r <= S_MERGE;
          end
        end
        S_MERGE: state_r <= S_START;
        S_START: state_r <= S_RUN;
        S_RUN: begin
          if (dist_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_ts_r         <= ts_r;
            out_pos_valid_r  <= merged.pos.ok;
            out_pos_x_r      <= merged.pos.x;
            out_pos_y_r      <= merged.pos.y;
            out_dist_valid_r <= dist_ok;
            out_dist_r       <= dist_ok ? dist_root : '0;
            out_bad_r        <= merged.bad;
            records_r        <= records_nxt;
            valid_seen_r     <= valid_seen_nxt;
            bad_seen_r       <= bad_seen_nxt;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.timestamp_out = out_ts_r;
  assign out_ch.pos_valid     = out_pos_valid_r;
  assign out_ch.pos_x         = out_pos_x_r;
  assign out_ch.pos_y         = out_pos_y_r;
  assign out_ch.dist_valid    = out_dist_valid_r;
  assign out_ch.led_distance  = out_dist_r;
  assign out_ch.out_of_range  = out_bad_r;
  assign out_ch.record_count  = records_r;
  assign out_ch.valid_count   = valid_seen_r;
  assign out_ch.bad_count     = bad_seen_r;

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [lte_pkg::TS_W-1:0]                               ts;
    logic [lte_pkg::TARGET_INPUTS-1:0][lte_pkg::WORD_W-1:0] words;
  } record_t;

  typedef struct packed {
    logic [lte_pkg::TS_W-1:0]   ts;
    logic                       pos_valid;
    logic [lte_pkg::CM_W-1:0]   pos_x;
    logic [lte_pkg::CM_W-1:0]   pos_y;
    logic                       dist_valid;
    logic [lte_pkg::DIST_W-1:0] led_distance;
    logic                       out_of_range;
    logic [lte_pkg::CNT_W-1:0]  record_count;
    logic [lte_pkg::CNT_W-1:0]  valid_count;
    logic [lte_pkg::CNT_W-1:0]  bad_count;
  } extract_t;

  typedef struct packed {
    logic                     ok;
    logic [lte_pkg::CM_W-1:0] x;
    logic [lte_pkg::CM_W-1:0] y;
  } led_spot_t;

  localparam logic [2:0] HUE_NONE  = 3'b000;
  localparam logic [2:0] HUE_BLUE  = 3'b001;
  localparam logic [2:0] HUE_GREEN = 3'b010;
  localparam logic [2:0] HUE_RED   = 3'b100;

  logic clk;
  logic rst_n;
  lte_in_if  in_ch ();
  lte_out_if out_ch ();
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [lte_pkg::PADDR_W-1:0] paddr;
  logic [lte_pkg::APB_W-1:0]   pwdata;
  logic [lte_pkg::APB_W-1:0]   prdata;
  logic                        pready;

  led_tracker_target_extract i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register mirror and counter state
  logic [lte_pkg::LEDC_W-1:0] led_count_m;
  logic [lte_pkg::PRIN_W-1:0] principal_m;
  logic [lte_pkg::PIX_W-1:0]  width_m;
  logic [lte_pkg::PIX_W-1:0]  height_m;
  logic [lte_pkg::CPP_W-1:0]  cpp_m;
  logic [lte_pkg::CNT_W-1:0]  seen_records;
  logic [lte_pkg::CNT_W-1:0]  seen_valid;
  logic [lte_pkg::CNT_W-1:0]  seen_bad;

  record_t  record_q[$];
  extract_t result_q[$];
  int queued_n;
  int accepted_n;
  int checked_n;
  int errors;
  int settings_n;
  int pos_hits;
  int dist_hits;
  int oor_hits;
  int tx_idle_pct;
  int rx_idle_pct;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.timestamp_us = '0;
    in_ch.target_word0 = '0;
    in_ch.target_word1 = '0;
    in_ch.target_word2 = '0;
    in_ch.target_word3 = '0;
    in_ch.target_word4 = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] b;
    root = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic extract_t extract_record(input record_t r);
    int n;
    logic [lte_pkg::PIX_W-1:0] x;
    logic [lte_pkg::PIX_W-1:0] y;
    logic [2:0] hue;
    led_spot_t cur;
    led_spot_t red;
    led_spot_t green;
    led_spot_t blue;
    led_spot_t pos;
    logic bad;
    logic [lte_pkg::CM_W-1:0] dx;
    logic [lte_pkg::CM_W-1:0] dy;
    logic [63:0] span;
    extract_t e;
    n = (led_count_m == 0) ? 1 : int'(led_count_m);
    if (n > lte_pkg::TARGET_INPUTS) n = lte_pkg::TARGET_INPUTS;
    cur = '0;
    red = '0;
    green = '0;
    blue = '0;
    bad = 1'b0;
    span = '0;
    for (int i = n - 1; i >= 0; i--) begin
      x = r.words[i][11:0];
      y = r.words[i][27:16];
      hue = r.words[i][30:28];
      if (x == 0 || x > width_m || y == 0 || y > height_m) begin
        cur = '0;
        bad = 1'b1;
      end else begin
        cur.ok = 1'b1;
        cur.x = lte_pkg::CM_W'(x) * lte_pkg::CM_W'(cpp_m);
        cur.y = lte_pkg::CM_W'(height_m - y) * lte_pkg::CM_W'(cpp_m);
      end
      case (hue)
        HUE_RED:   red = cur;
        HUE_GREEN: green = cur;
        HUE_BLUE:  blue = cur;
        default: ;
      endcase
    end
    case (principal_m)
      lte_pkg::PL_RED:   pos = red;
      lte_pkg::PL_GREEN: pos = green;
      lte_pkg::PL_BLUE:  pos = blue;
      default:           pos = cur;
    endcase
    if (red.ok && blue.ok) begin
      dx = (red.x > blue.x) ? red.x - blue.x : blue.x - red.x;
      dy = (red.y > blue.y) ? red.y - blue.y : blue.y - red.y;
      span = root_floor(64'(dx) * 64'(dx) + 64'(dy) * 64'(dy));
    end
    if (seen_records != '1) seen_records++;
    if (pos.ok && seen_valid != '1) seen_valid++;
    if (bad && seen_bad != '1) seen_bad++;
    pos_hits += int'(pos.ok);
    dist_hits += int'(red.ok && blue.ok);
    oor_hits += int'(bad);
    e.ts = r.ts;
    e.pos_valid = pos.ok;
    e.pos_x = pos.ok ? pos.x : '0;
    e.pos_y = pos.ok ? pos.y : '0;
    e.dist_valid = red.ok && blue.ok;
    e.led_distance = span[lte_pkg::DIST_W-1:0];
    e.out_of_range = bad;
    e.record_count = seen_records;
    e.valid_count = seen_valid;
    e.bad_count = seen_bad;
    return e;
  endfunction

  always @(posedge clk) begin : drive_records
    record_t next_rec;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        next_rec.ts = in_ch.timestamp_us;
        next_rec.words[0] = in_ch.target_word0;
        next_rec.words[1] = in_ch.target_word1;
        next_rec.words[2] = in_ch.target_word2;
        next_rec.words[3] = in_ch.target_word3;
        next_rec.words[4] = in_ch.target_word4;
        result_q.push_back(extract_record(next_rec));
        accepted_n++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (record_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_rec = record_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.timestamp_us <= next_rec.ts;
          in_ch.target_word0 <= next_rec.words[0];
          in_ch.target_word1 <= next_rec.words[1];
          in_ch.target_word2 <= next_rec.words[2];
          in_ch.target_word3 <= next_rec.words[3];
          in_ch.target_word4 <= next_rec.words[4];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    extract_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, timestamp %0h", $time, out_ch.timestamp_out);
          errors++;
        end else begin
          want = result_q.pop_front();
          compare_field("timestamp_out", 64'(want.ts), 64'(out_ch.timestamp_out));
          compare_field("pos_valid", 64'(want.pos_valid), 64'(out_ch.pos_valid));
          compare_field("pos_x", 64'(want.pos_x), 64'(out_ch.pos_x));
          compare_field("pos_y", 64'(want.pos_y), 64'(out_ch.pos_y));
          compare_field("dist_valid", 64'(want.dist_valid), 64'(out_ch.dist_valid));
          compare_field("led_distance", 64'(want.led_distance), 64'(out_ch.led_distance));
          compare_field("out_of_range", 64'(want.out_of_range), 64'(out_ch.out_of_range));
          compare_field("record_count", 64'(want.record_count), 64'(out_ch.record_count));
          compare_field("valid_count", 64'(want.valid_count), 64'(out_ch.valid_count));
          compare_field("bad_count", 64'(want.bad_count), 64'(out_ch.bad_count));
          checked_n++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic wait_drained;
    do @(negedge clk); while (accepted_n != queued_n || result_q.size() != 0);
  endtask

  task automatic apb_write(input logic [lte_pkg::REG_IDX_W-1:0] idx,
                           input logic [lte_pkg::APB_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      lte_pkg::REG_LED_COUNT:     led_count_m = data[lte_pkg::LEDC_W-1:0];
      lte_pkg::REG_PRINCIPAL_LED: principal_m = data[lte_pkg::PRIN_W-1:0];
      lte_pkg::REG_FRAME_WIDTH:   width_m = data[lte_pkg::PIX_W-1:0];
      lte_pkg::REG_FRAME_HEIGHT:  height_m = data[lte_pkg::PIX_W-1:0];
      lte_pkg::REG_CM_PER_PIXEL:  cpp_m = data[lte_pkg::CPP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int lc, input logic [lte_pkg::PRIN_W-1:0] pl, input int w,
                            input int h, input int cpp);
    wait_drained();
    apb_write(lte_pkg::REG_LED_COUNT, lte_pkg::APB_W'(lc));
    apb_write(lte_pkg::REG_PRINCIPAL_LED, lte_pkg::APB_W'(pl));
    apb_write(lte_pkg::REG_FRAME_WIDTH, lte_pkg::APB_W'(w));
    apb_write(lte_pkg::REG_FRAME_HEIGHT, lte_pkg::APB_W'(h));
    apb_write(lte_pkg::REG_CM_PER_PIXEL, lte_pkg::APB_W'(cpp));
    settings_n++;
  endtask

  function automatic logic [lte_pkg::WORD_W-1:0] tgt(input int x, input int y,
                                                     input logic [2:0] hue);
    return {1'b0, hue, lte_pkg::PIX_W'(y), 4'h0, lte_pkg::PIX_W'(x)};
  endfunction

  task automatic push_record(input logic [lte_pkg::TS_W-1:0] ts,
                             input logic [lte_pkg::WORD_W-1:0] w0,
                             input logic [lte_pkg::WORD_W-1:0] w1,
                             input logic [lte_pkg::WORD_W-1:0] w2,
                             input logic [lte_pkg::WORD_W-1:0] w3,
                             input logic [lte_pkg::WORD_W-1:0] w4);
    record_t r;
    r.ts = ts;
    r.words = {w4, w3, w2, w1, w0};
    record_q.push_back(r);
    queued_n++;
  endtask

  function automatic logic [lte_pkg::PIX_W-1:0] pick_coord(
      input logic [lte_pkg::PIX_W-1:0] lim);
    int sel;
    sel = $urandom_range(19);
    case (sel)
      0: return '0;
      1: return lim;
      2: return lim + 1'b1;
      3: return lte_pkg::PIX_W'($urandom);
      4: return lte_pkg::PIX_W'(1);
      default: return (lim == 0) ? '0 : lte_pkg::PIX_W'($urandom_range(lim, 1));
    endcase
  endfunction

  function automatic logic [lte_pkg::WORD_W-1:0] pick_target();
    logic [lte_pkg::WORD_W-1:0] w;
    w = $urandom;
    w[11:0] = pick_coord(width_m);
    w[27:16] = pick_coord(height_m);
    // mostly single-colour targets, the rest any colour mix
    if ($urandom_range(99) < 80) w[30:28] = 3'b001 << $urandom_range(2);
    return w;
  endfunction

  task automatic push_random;
    push_record({$urandom, $urandom}, pick_target(), pick_target(), pick_target(),
                pick_target(), pick_target());
  endtask

  initial begin
    led_count_m = lte_pkg::LED_COUNT_RST;
    principal_m = lte_pkg::PRINCIPAL_LED_RST;
    width_m = lte_pkg::FRAME_WIDTH_RST;
    height_m = lte_pkg::FRAME_HEIGHT_RST;
    cpp_m = lte_pkg::CM_PER_PIXEL_RST;
    seen_records = '0;
    seen_valid = '0;
    seen_bad = '0;
    tx_idle_pct = 13;
    rx_idle_pct = 51;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults
    push_record('0, '0, '0, '0, '0, '0);
    push_record('1, tgt(641, 481, HUE_NONE), '0, '0, '0, '0);
    push_record({$urandom, $urandom}, tgt(1, 1, HUE_RED), '1, '0, '0, '0);
    push_record({$urandom, $urandom}, tgt(642, 1, HUE_BLUE), '0, '0, '0, '0);
    push_record({$urandom, $urandom}, tgt(1, 482, HUE_NONE), '0, '0, '0, '0);
    push_record({$urandom, $urandom}, '1, '1, '1, '1, '1);

    set_config(5, lte_pkg::PL_RED, 641, 481, 256);
    push_record({$urandom, $urandom}, tgt(0, 5, HUE_RED), tgt(9, 9, HUE_NONE),
                tgt(30, 40, HUE_BLUE), tgt(50, 60, HUE_RED), tgt(7, 7, HUE_GREEN));
    push_record({$urandom, $urandom}, tgt(300, 200, HUE_NONE), tgt(10, 20, HUE_RED),
                tgt(5, 5, HUE_GREEN), tgt(641, 481, HUE_NONE), tgt(600, 400, HUE_BLUE));
    push_record({$urandom, $urandom}, tgt(100, 100, HUE_RED | HUE_BLUE),
                tgt(20, 30, HUE_RED), tgt(40, 50, HUE_BLUE), '0, tgt(1, 1, 3'b111));
    push_record({$urandom, $urandom}, tgt(11, 12, HUE_NONE), tgt(13, 14, HUE_NONE),
                tgt(15, 16, HUE_NONE), tgt(17, 18, HUE_NONE), tgt(19, 20, HUE_NONE));
    push_record({$urandom, $urandom}, tgt(2, 3, HUE_BLUE), tgt(4, 5, HUE_GREEN),
                tgt(640, 480, HUE_RED), tgt(6, 7, HUE_NONE), tgt(8, 9, HUE_RED));

    set_config(5, lte_pkg::PL_GREEN, 641, 481, 256);
    push_record({$urandom, $urandom}, tgt(1, 2, HUE_NONE), tgt(33, 0, HUE_GREEN),
                tgt(3, 4, HUE_NONE), tgt(44, 55, HUE_GREEN), tgt(5, 6, HUE_NONE));
    push_record({$urandom, $urandom}, tgt(123, 321, HUE_GREEN), '0, '0, '0, '0);

    set_config(5, lte_pkg::PL_BLUE, 4095, 4095, 65535);
    push_record('1, tgt(4095, 1, HUE_RED), tgt(1, 4095, HUE_BLUE), '0, '0, '0);
    push_record({$urandom, $urandom}, tgt(4095, 4095, HUE_BLUE), tgt(4095, 4095, HUE_RED),
                tgt(1, 1, HUE_GREEN), tgt(2048, 2048, HUE_NONE), '1);

    set_config(0, lte_pkg::PL_TARGET0, 0, 0, 1);
    push_record({$urandom, $urandom}, tgt(1, 1, HUE_RED), tgt(4095, 0, HUE_NONE),
                '0, '0, '0);

    set_config(7, lte_pkg::PL_RED, 1, 1, 0);
    push_record({$urandom, $urandom}, tgt(1, 1, HUE_RED), tgt(1, 1, HUE_BLUE),
                tgt(1, 1, HUE_GREEN), tgt(1, 1, HUE_NONE), tgt(1, 1, HUE_NONE));
    push_record({$urandom, $urandom}, tgt(2, 1, HUE_RED), tgt(1, 1, HUE_BLUE),
                tgt(1, 1, HUE_RED), tgt(1, 2, HUE_NONE), tgt(1, 1, HUE_NONE));

    set_config(6, lte_pkg::PL_TARGET0, 4095, 1, 1);
    push_record({$urandom, $urandom}, tgt(4095, 1, HUE_RED), tgt(7, 1, HUE_BLUE),
                tgt(8, 1, HUE_NONE), tgt(9, 1, HUE_NONE), tgt(10, 2, HUE_NONE));

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(5, lte_pkg::PRIN_W'($urandom_range(3)), 641, 481, 256);
        1: set_config(7, lte_pkg::PL_RED, $urandom_range(4095, 1), $urandom_range(4095, 1),
                      $urandom_range(65535, 1));
        2: set_config(3, lte_pkg::PL_BLUE, 4095, 4095, 65535);
        3: set_config(5, lte_pkg::PL_GREEN, $urandom_range(4095, 1),
                      $urandom_range(4095, 1), $urandom_range(65535));
        4: set_config(6, lte_pkg::PL_TARGET0, 100, 60, 1);
        default: set_config($urandom_range(5, 1), lte_pkg::PRIN_W'($urandom_range(3)),
                            $urandom_range(4095, 1), $urandom_range(4095, 1),
                            $urandom_range(65535, 1));
      endcase
      if (p >= 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (p >= 2) begin
        tx_idle_pct = 51;
        rx_idle_pct = 13;
      end
      repeat (125) push_random();
    end

    wait_drained();
    repeat (60) @(posedge clk);
    $display("Checked %0d records across %0d register settings.", checked_n, settings_n);
    $display("%0d had a valid position, %0d a valid distance, %0d an out-of-range target.",
             pos_hits, dist_hits, oor_hits);
    if (errors == 0 && result_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
